// ===== design/paren_expression_evaluator_top_assert.svh =====
// Assertion macros for the parenthesized expression evaluator.
`ifndef PAREN_EXPRESSION_EVALUATOR_TOP_ASSERT_SVH
`define PAREN_EXPRESSION_EVALUATOR_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PEE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PEE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== design/pee_pkg.sv =====
// Package with types and constants of the parenthesized expression evaluator.
package pee_pkg;
	localparam int STACK_DEPTH_DEF = 64;
	localparam int ENTRY_W = 33;
	localparam logic [7:0] CH_LP = 8'h28;
	localparam logic [7:0] CH_RP = 8'h29;
	localparam logic [7:0] CH_ADD = 8'h2B;
	localparam logic [7:0] CH_SUB = 8'h2D;
	localparam logic [7:0] CH_MUL = 8'h2A;
	localparam logic [7:0] CH_DIV = 8'h2F;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_SYNTAX = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;

	typedef struct packed {
		logic [7:0] ch;
		logic last;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [1:0] status;
	} out_word_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sd2147483647) r = 32'sh7FFFFFFF;
		else if (v < -66'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction
endpackage

// ===== design/paren_expression_evaluator_top.sv =====
// Parenthesized expression evaluator: stack in RAM, sequencer, iterative divider.
// Digits, symbols and ignored characters are taken one per cycle until a word marked last.
// A closing parenthesis reads four stack entries in S_RD/S_CAP, checks them in S_CHK and
// pushes in S_PUSH; multiply adds the S_MUL state and divide adds 48 divider steps.
// The last word's result passes S_FIN, S_FRD and S_OUT; a held result stalls only the next.
// Reset clears all control state; the RAM has no reset; only data below the pointer is used.
`include "paren_expression_evaluator_top_assert.svh"
module paren_expression_evaluator_top
	import pee_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_word_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_word_t out_data
);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int PW = $clog2(STACK_DEPTH + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD = 4'd1;
	localparam logic [3:0] S_CAP = 4'd2;
	localparam logic [3:0] S_CHK = 4'd3;
	localparam logic [3:0] S_MUL = 4'd4;
	localparam logic [3:0] S_DIV = 4'd5;
	localparam logic [3:0] S_PUSH = 4'd6;
	localparam logic [3:0] S_FIN = 4'd7;
	localparam logic [3:0] S_FRD = 4'd8;
	localparam logic [3:0] S_OUT = 4'd9;

	logic [3:0] state_q;
	logic [PW-1:0] sp_q;
	logic [15:0] bal_q;
	logic first_q, fbad_q;
	logic [1:0] err_q;
	logic last_q;
	logic [1:0] rcnt_q;
	logic [ENTRY_W-1:0] eb_q, eo_q, ea_q, ep_q;
	logic signed [31:0] res_q;
	logic signed [65:0] prod_q;
	logic [63:0] dnum_q;
	logic [63:0] drem_q;
	logic [31:0] dden_q;
	logic [5:0] dcnt_q;
	logic dneg_q;
	out_word_t out_q;
	logic out_v_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [ENTRY_W-1:0] wdata, rdata;

	pee_ram #(.WIDTH(ENTRY_W), .DEPTH(STACK_DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// The result register parts the two sides: only a new result waits for it.
	logic out_take;
	assign out_take = (state_q == S_OUT) && (!out_v_q || out_ready);

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_v_q;
	assign out_data = out_q;

	logic acc;
	logic [7:0] cin;
	logic is_digit, is_sym, full;
	assign acc = in_valid && in_ready;
	assign cin = in_data.ch;
	assign is_digit = (cin >= CH_ZERO) && (cin <= CH_NINE);
	assign is_sym = (cin == CH_LP) || (cin == CH_ADD) || (cin == CH_SUB) ||
		(cin == CH_MUL) || (cin == CH_DIV);
	assign full = (sp_q == PW'(STACK_DEPTH));

	// Reads go down from the top: rcnt 0 is the top entry.
	logic [PW-1:0] rd_idx;
	assign rd_idx = sp_q - PW'(rcnt_q) - PW'(1);
	assign raddr = (state_q == S_FIN) ? AW'(sp_q - PW'(1)) : rd_idx[AW-1:0];

	logic [7:0] op;
	logic shape_ok;
	assign op = eo_q[7:0];
	assign shape_ok = eb_q[32] && !eo_q[32] && ea_q[32] && !ep_q[32] &&
		(ep_q[31:0] == 32'(CH_LP)) &&
		((op == CH_ADD) || (op == CH_SUB) || (op == CH_MUL) || (op == CH_DIV));

	logic signed [31:0] av, bv;
	assign av = ea_q[31:0];
	assign bv = eb_q[31:0];

	// Restoring divider step on magnitudes.
	logic [64:0] trial;
	assign trial = {drem_q, dnum_q[63]} - {33'd0, dden_q};

	logic [1:0] fin_status;
	logic signed [31:0] fin_value;
	logic [63:0] qmag;
	logic signed [65:0] qs;
	// The numerator sits in the top 32 bits, so after 48 steps the quotient fills the low bits.
	assign qmag = {dnum_q[62:0], !trial[64]};
	assign qs = dneg_q ? -$signed({2'b00, qmag}) : $signed({2'b00, qmag});

	always_comb begin
		we = 1'b0;
		waddr = sp_q[AW-1:0];
		wdata = '0;
		if (acc && err_q == ST_OK && !full && (is_digit || is_sym)) begin
			we = 1'b1;
			wdata = is_digit ? {1'b1, 12'd0, 4'(cin - CH_ZERO), 16'd0} : {1'b0, 24'd0, cin};
		end else if (state_q == S_PUSH) begin
			we = 1'b1;
			waddr = AW'(sp_q - PW'(4));
			wdata = {1'b1, res_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sp_q <= '0;
			bal_q <= '0;
			first_q <= 1'b1;
			fbad_q <= 1'b0;
			err_q <= ST_OK;
			out_v_q <= 1'b0;
			rcnt_q <= '0;
			dcnt_q <= '0;
		end else begin
			if (out_v_q && out_ready && !out_take) out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						last_q <= in_data.last;
						if (first_q) begin
							fbad_q <= (cin != CH_LP);
							first_q <= 1'b0;
						end
						if (cin == CH_LP) bal_q <= bal_q + 16'd1;
						if (cin == CH_RP) bal_q <= bal_q - 16'd1;
						rcnt_q <= '0;
						if (err_q == ST_OK && (is_digit || is_sym)) begin
							if (full) err_q <= ST_SYNTAX;
							else sp_q <= sp_q + PW'(1);
							state_q <= in_data.last ? S_FIN : S_IDLE;
						end else if (err_q == ST_OK && cin == CH_RP) begin
							if (sp_q < PW'(4)) begin
								err_q <= ST_SYNTAX;
								state_q <= in_data.last ? S_FIN : S_IDLE;
							end else begin
								state_q <= S_RD;
							end
						end else begin
							state_q <= in_data.last ? S_FIN : S_IDLE;
						end
					end
				end
				S_RD: begin
					// Address rcnt issued; data arrives next cycle.
					state_q <= S_CAP;
				end
				S_CAP: begin
					case (rcnt_q)
						2'd0: eb_q <= rdata;
						2'd1: eo_q <= rdata;
						2'd2: ea_q <= rdata;
						default: ep_q <= rdata;
					endcase
					rcnt_q <= rcnt_q + 2'd1;
					state_q <= (rcnt_q == 2'd3) ? S_CHK : S_RD;
				end
				S_CHK: begin
					if (!shape_ok) begin
						err_q <= ST_SYNTAX;
						state_q <= last_q ? S_FIN : S_IDLE;
					end else if (op == CH_DIV && bv == 32'sd0) begin
						err_q <= ST_DIV0;
						state_q <= last_q ? S_FIN : S_IDLE;
					end else if (op == CH_ADD) begin
						res_q <= sat32(66'(av) + 66'(bv));
						state_q <= S_PUSH;
					end else if (op == CH_SUB) begin
						res_q <= sat32(66'(av) - 66'(bv));
						state_q <= S_PUSH;
					end else if (op == CH_MUL) begin
						prod_q <= 66'(av) * 66'(bv);
						state_q <= S_MUL;
					end else begin
						dnum_q <= {(av[31] ? 32'(-33'(av)) : 32'(av)), 32'd0};
						dden_q <= bv[31] ? 32'(-33'(bv)) : 32'(bv);
						dneg_q <= av[31] ^ bv[31];
						drem_q <= '0;
						dcnt_q <= '0;
						state_q <= S_DIV;
					end
				end
				S_MUL: begin
					// Truncate toward zero: bias negatives before the shift.
					res_q <= sat32((prod_q + (prod_q[65] ? 66'sd65535 : 66'sd0)) >>> 16);
					state_q <= S_PUSH;
				end
				S_DIV: begin
					if (!trial[64]) begin
						drem_q <= trial[63:0];
						dnum_q <= {dnum_q[62:0], 1'b1};
					end else begin
						drem_q <= {drem_q[62:0], dnum_q[63]};
						dnum_q <= {dnum_q[62:0], 1'b0};
					end
					if (dcnt_q == 6'd47) begin
						res_q <= sat32(qs);
						state_q <= S_PUSH;
						dcnt_q <= '0;
					end else begin
						dcnt_q <= dcnt_q + 6'd1;
					end
				end
				S_PUSH: begin
					sp_q <= sp_q - PW'(3);
					state_q <= last_q ? S_FIN : S_IDLE;
				end
				S_FIN: state_q <= S_FRD;
				S_FRD: state_q <= S_OUT;
				S_OUT: begin
					if (out_take) begin
						out_q.status <= fin_status;
						out_q.result_value <= fin_value;
						out_v_q <= 1'b1;
						sp_q <= '0;
						bal_q <= '0;
						first_q <= 1'b1;
						fbad_q <= 1'b0;
						err_q <= ST_OK;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	logic [ENTRY_W-1:0] top_q;
	always_ff @(posedge clk) begin
		if (state_q == S_FRD) top_q <= rdata;
	end

	always_comb begin
		fin_value = '0;
		if (fbad_q || bal_q != 16'd0) fin_status = ST_SYNTAX;
		else if (err_q != ST_OK) fin_status = err_q;
		else if (sp_q != '0 && top_q[32]) begin
			fin_status = ST_OK;
			fin_value = top_q[31:0];
		end else fin_status = ST_SYNTAX;
	end

	`PEE_ASSERT_IMPL(a_ready_idle, clk, arst_n, in_ready, state_q == S_IDLE)
	`PEE_ASSERT_IMPL(a_sp_bound, clk, arst_n, 1'b1, sp_q <= PW'(STACK_DEPTH))
	`PEE_ASSERT_NEXT(a_out_from_fin, clk, arst_n, state_q == S_OUT, out_v_q)
	`PEE_ASSERT_IMPL(a_status_range, clk, arst_n, out_v_q, out_q.status != 2'd3)
endmodule

// ===== design/pee_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module pee_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 64
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
